/* hdl/npc_pkg.sv */
// package for the nearest palette color search: shared types, opcodes and constants
// used by the interfaces, the palette memory, the scan unit, the top level and the checker
`default_nettype none

package npc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int CHAN_W          = 8;
  localparam int COLOR_W         = 3 * CHAN_W;
  localparam int INDEX_W         = 8;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int DIST_W          = SQ_W + 2;

  // above any real distance, so entry 0 always wins the first compare
  localparam logic [DIST_W-1:0] START_DIST = DIST_W'(256 * 256 * 3);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               done;
    logic [INDEX_W-1:0] nearest_index;
  } npc_scan_rsp_t;

endpackage

`default_nettype wire

/* hdl/npc_if.sv */
// valid/ready channel interfaces for input items and result items
// depends on npc_pkg for field widths
`default_nettype none

interface npc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [npc_pkg::INDEX_W-1:0] entry_index;
  logic [npc_pkg::CHAN_W-1:0]  red;
  logic [npc_pkg::CHAN_W-1:0]  green;
  logic [npc_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, op, entry_index, red, green, blue, input ready);
  modport sink   (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface npc_out_if;
  logic                        valid;
  logic                        ready;
  logic [npc_pkg::INDEX_W-1:0] nearest_index;

  modport source (output valid, nearest_index, input ready);
  modport sink   (input valid, nearest_index, output ready);
endinterface

`default_nettype wire

/* hdl/npc_palette_mem.sv */
// palette storage: one write port, one read port, registered read data
// depends on npc_pkg for the color width
`default_nettype none

module npc_palette_mem #(
  parameter int PaletteEntries = npc_pkg::PALETTE_ENTRIES,
  localparam int AddrW = $clog2(PaletteEntries)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AddrW-1:0]            wr_addr_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_i,
  output      logic [npc_pkg::COLOR_W-1:0] rd_data_o
);

  logic [npc_pkg::COLOR_W-1:0] mem_q [PaletteEntries];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/npc_scan.sv */
// scan unit: walks the palette one entry per cycle, squares the channel
// differences, sums them and keeps the first least distance; depends on npc_pkg
`default_nettype none

module npc_scan #(
  parameter int PaletteEntries = npc_pkg::PALETTE_ENTRIES,
  localparam int AddrW = $clog2(PaletteEntries)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] color_i,
  output      logic                        rd_en_o,
  output      logic [AddrW-1:0]            rd_addr_o,
  input  wire logic [npc_pkg::COLOR_W-1:0] rd_data_i,
  output      npc_pkg::npc_scan_rsp_t      rsp_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(PaletteEntries - 1);
  localparam int CW = npc_pkg::CHAN_W;
  localparam int SW = npc_pkg::SQ_W;
  localparam int DW = npc_pkg::DIST_W;

  logic             busy_q, busy_d;
  logic [AddrW-1:0] addr_q, addr_d;

  logic             v1_q, last1_q;
  logic [AddrW-1:0] idx1_q;

  logic             v2_q, last2_q;
  logic [AddrW-1:0] idx2_q;
  logic [SW-1:0]    sq_r_q, sq_g_q, sq_b_q;

  logic [DW-1:0]    best_dist_q, best_dist_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  logic             done_q;

  logic [CW-1:0]    dr, dg, db;
  logic [DW-1:0]    dist_sum;
  logic [AddrW+7:0] best_ext;

  // stage 0: address counter
  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (start_i) begin
      busy_d = 1'b1;
      addr_d = '0;
    end else if (busy_q) begin
      addr_d = addr_q + AddrW'(1);
      if (addr_q == LastAddr) begin
        busy_d = 1'b0;
      end
    end
  end

  assign rd_en_o   = busy_q;
  assign rd_addr_o = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      addr_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
      v1_q   <= busy_q;
      v2_q   <= v1_q;
      done_q <= v2_q && last2_q;
    end
  end

  // stage 1: memory data arrives, absolute differences and squares
  always_ff @(posedge clk_i) begin
    idx1_q  <= addr_q;
    last1_q <= (addr_q == LastAddr);
  end

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign dr = abs_diff(rd_data_i[3*CW-1:2*CW], color_i[3*CW-1:2*CW]);
  assign dg = abs_diff(rd_data_i[2*CW-1:CW], color_i[2*CW-1:CW]);
  assign db = abs_diff(rd_data_i[CW-1:0], color_i[CW-1:0]);

  always_ff @(posedge clk_i) begin
    idx2_q  <= idx1_q;
    last2_q <= last1_q;
    sq_r_q  <= SW'(dr) * SW'(dr);
    sq_g_q  <= SW'(dg) * SW'(dg);
    sq_b_q  <= SW'(db) * SW'(db);
  end

  // stage 2: sum and compare against the running best
  assign dist_sum = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (start_i) begin
      best_dist_d = npc_pkg::START_DIST;
      best_idx_d  = '0;
    end else if (v2_q && (dist_sum < best_dist_q)) begin
      best_dist_d = dist_sum;
      best_idx_d  = idx2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
  end

  assign best_ext            = {8'b0, best_idx_q};
  assign rsp_o.done          = done_q;
  assign rsp_o.nearest_index = best_ext[npc_pkg::INDEX_W-1:0];

endmodule

`default_nettype wire

/* hdl/nearest_palette_color_top.sv */
// top level of the nearest palette color search: channel handshakes, one-entry cache,
// sequencing of loads and scans; depends on npc_pkg, npc_if, npc_palette_mem, npc_scan
//
// usage:
//   in_i carries items: op load writes palette[entry_index] = {red, green, blue},
//   op query asks for the palette index nearest to {red, green, blue}.
//   out_o carries one nearest_index per query and nothing per load.
//   a load is taken whenever no scan runs. a query of the same color as the last
//   scanned query, with no load in between, is answered from the cache with a
//   result registered in the cycle after its transfer. any other query scans the
//   palette memory, one entry read per cycle through its single read port, and
//   its result passes the scan stages and the done flag into the output register;
//   the block takes no item during a scan.
//   the result sits in an output register: while it waits, loads are still
//   taken, queries wait until the register is free or draining.
//   reset clears the cache and the output register; the palette is not cleared
//   and every entry must be loaded before a query scans it. no clearing pass.
//   a load with entry_index at or above PaletteEntries only invalidates the cache.
`default_nettype none

module nearest_palette_color_top #(
  parameter int PaletteEntries = npc_pkg::PALETTE_ENTRIES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  npc_in_if.sink    in_i,
  npc_out_if.source out_o
);

  localparam int AddrW = $clog2(PaletteEntries);
  localparam int CW    = npc_pkg::COLOR_W;
  localparam int IW    = npc_pkg::INDEX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;

  logic          cache_valid_q, cache_valid_d;
  logic [CW-1:0] last_color_q, last_color_d;
  logic [IW-1:0] last_answer_q, last_answer_d;

  logic          out_valid_q, out_valid_d;
  logic [IW-1:0] out_index_q, out_index_d;

  logic          out_free, xfer, is_load, hit, scan_start;
  logic [CW-1:0] in_color;
  logic          wr_ok;
  logic [AddrW+7:0] wr_addr_ext;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [CW-1:0]    rd_data;
  npc_pkg::npc_scan_rsp_t scan_rsp;

  assign out_free  = !out_valid_q || out_o.ready;
  assign is_load   = (in_i.op == npc_pkg::OP_LOAD);
  assign in_i.ready = (state_q == ST_IDLE) && (is_load || out_free);
  assign xfer      = in_i.valid && in_i.ready;
  assign in_color  = {in_i.red, in_i.green, in_i.blue};
  assign hit       = cache_valid_q && (in_color == last_color_q);
  assign scan_start = xfer && !is_load && !hit;

  assign wr_ok       = (32'(in_i.entry_index) < PaletteEntries);
  assign wr_addr_ext = {{AddrW{1'b0}}, in_i.entry_index};

  always_comb begin
    state_d       = state_q;
    cache_valid_d = cache_valid_q;
    last_color_d  = last_color_q;
    last_answer_d = last_answer_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_index_d   = out_index_q;
    unique case (state_q)
      ST_IDLE: begin
        if (xfer) begin
          if (is_load) begin
            cache_valid_d = 1'b0;
          end else if (hit) begin
            out_valid_d = 1'b1;
            out_index_d = last_answer_q;
          end else begin
            last_color_d = in_color;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          cache_valid_d = 1'b1;
          last_answer_d = scan_rsp.nearest_index;
          out_valid_d   = 1'b1;
          out_index_d   = scan_rsp.nearest_index;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cache_valid_q <= 1'b0;
      last_color_q  <= '0;
      last_answer_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cache_valid_q <= cache_valid_d;
      last_color_q  <= last_color_d;
      last_answer_q <= last_answer_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.nearest_index = out_index_q;

  npc_palette_mem #(
    .PaletteEntries(PaletteEntries)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (xfer && is_load && wr_ok),
    .wr_addr_i(wr_addr_ext[AddrW-1:0]),
    .wr_data_i(in_color),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  npc_scan #(
    .PaletteEntries(PaletteEntries)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .color_i  (last_color_q),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .rsp_o    (scan_rsp)
  );

endmodule

`default_nettype wire

/* hdl/npc_checker.sv */
// port-level checker for the nearest palette color search, bound to the top level
// depends on npc_pkg for opcodes and widths
`default_nettype none

module npc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        in_op_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [npc_pkg::INDEX_W-1:0] out_index_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i))
    else $error("result changed while stalled");

  // a load never makes a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_op_i == npc_pkg::OP_LOAD) && !out_valid_i |=> !out_valid_i)
    else $error("result appeared after a load");

  // a query either answers from the cache at once or starts a scan
  a_query_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_op_i == npc_pkg::OP_QUERY) |=> out_valid_i || !in_ready_i)
    else $error("query neither answered nor scanning");

  // a query is only taken when the result register can hold its answer
  a_query_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_op_i == npc_pkg::OP_QUERY) |-> !out_valid_i || out_ready_i)
    else $error("query taken while result register blocked");

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_op_i    (in_i.op),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_index_i(out_o.nearest_index)
);

`default_nettype wire

/* tb/nearest_palette_color_top_test.sv */
`timescale 1ns / 1ps
// testbench for nearest_palette_color_top: load and query transfers with random gaps,
// each nearest index predicted from a shadow palette and cache, checked in order
// depends on npc_pkg, npc_in_if, npc_out_if and the top level

module nearest_palette_color_top_test;

  localparam int COLOR_W         = npc_pkg::COLOR_W;
  localparam int INDEX_W         = npc_pkg::INDEX_W;
  localparam int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES;

  localparam int unsigned FAR_DIST = 3 * 256 * 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  npc_in_if  in_if ();
  npc_out_if out_if ();

  nearest_palette_color_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  logic [COLOR_W-1:0] pal_shadow [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] cached_color = '0;
  logic [INDEX_W-1:0] cached_index = '0;
  logic               cache_live = 1'b0;
  logic [INDEX_W-1:0] expected_index_q [$];
  logic [COLOR_W-1:0] last_query_color = '0;

  int unsigned idle_pct = 0;
  int unsigned hold_off_req = 0;
  int unsigned error_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 19) != 0) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [INDEX_W-1:0] nearest_in_palette(input logic [COLOR_W-1:0] color);
    int unsigned        best_dist;
    int unsigned        sq_dist;
    int                 dr, dg, db;
    logic [INDEX_W-1:0] best;
    best_dist = FAR_DIST;
    best = '0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr = int'(pal_shadow[i][23:16]) - int'(color[23:16]);
      dg = int'(pal_shadow[i][15:8]) - int'(color[15:8]);
      db = int'(pal_shadow[i][7:0]) - int'(color[7:0]);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best = INDEX_W'(i);
      end
    end
    return best;
  endfunction

  function automatic void track_transfer(input logic op, input logic [INDEX_W-1:0] idx,
                                         input logic [COLOR_W-1:0] color);
    if (op == npc_pkg::OP_LOAD) begin
      pal_shadow[idx] = color;
      cache_live = 1'b0;
    end else begin
      if (!(cache_live && color == cached_color)) begin
        cached_index = nearest_in_palette(color);
        cached_color = color;
        cache_live = 1'b1;
      end
      expected_index_q.push_back(cached_index);
    end
  endfunction

  function automatic void check_nearest(input logic [INDEX_W-1:0] got);
    logic [INDEX_W-1:0] want;
    if (expected_index_q.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("%0t: unexpected result, nearest_index %0d", $time, got);
    end else begin
      want = expected_index_q.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: nearest_index mismatch, expected %0d, got %0d", $time, want, got);
      end
    end
  endfunction

  task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.entry_index <= idx;
    in_if.red         <= color[23:16];
    in_if.green       <= color[15:8];
    in_if.blue        <= color[7:0];
    do @(posedge clk); while (in_if.ready !== 1'b1);
    track_transfer(op, idx, color);
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color);
    send_item(npc_pkg::OP_LOAD, idx, color);
  endtask

  task automatic send_query(input logic [COLOR_W-1:0] color);
    last_query_color = color;
    send_item(npc_pkg::OP_QUERY, INDEX_W'($urandom), color);
  endtask

  // flat fills every entry with one color, otherwise random with black at 0 and white at 255
  task automatic fill_palette(input bit flat, input logic [COLOR_W-1:0] flat_color);
    logic [COLOR_W-1:0] color;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (flat) color = flat_color;
      else if (i == 0) color = 24'h000000;
      else if (i == PALETTE_ENTRIES - 1) color = 24'hffffff;
      else color = COLOR_W'($urandom);
      send_load(INDEX_W'(i), color);
    end
  endtask

  task automatic test_palette_fill();
    idle_pct = 10;
    fill_palette(1'b0, '0);
  endtask

  task automatic test_directed_queries();
    idle_pct = 0;
    send_query(24'h000000);
    send_query(24'hffffff);
    send_query(24'hffffff);
    send_query(24'hff0000);
    send_query(24'h00ff00);
    send_query(24'h0000ff);
    send_load(8'd100, 24'h808080);
    send_query(24'h808080);
    send_query(24'h808080);
    // load between equal queries forces a new scan
    send_load(8'd100, 24'h010203);
    send_query(24'h808080);
    send_query(pal_shadow[37]);
  endtask

  task automatic test_tie_break();
    idle_pct = 20;
    send_load(8'd20, 24'h5a3c1e);
    send_load(8'd21, 24'h5a3c1e);
    send_query(24'h5a3c1e);
    // equal distance to both neighbors
    send_load(8'd30, 24'h101010);
    send_load(8'd31, 24'h141414);
    send_query(24'h121212);
  endtask

  task automatic test_far_query();
    idle_pct = 5;
    fill_palette(1'b1, 24'h000000);
    send_query(24'hffffff);
    send_query(24'h000000);
    fill_palette(1'b0, '0);
  endtask

  task automatic test_output_stall();
    idle_pct = 0;
    hold_off_req = 700;
    send_query(COLOR_W'($urandom));
    send_load(INDEX_W'($urandom), COLOR_W'($urandom));
    send_query(COLOR_W'($urandom));
    send_query(last_query_color);
    for (int i = 0; i < 6; i++) begin
      send_load(INDEX_W'($urandom), COLOR_W'($urandom));
      send_query(COLOR_W'($urandom));
      send_query(last_query_color);
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned        roll;
    int unsigned        pick;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] base;
    for (int k = 0; k < n_items; k++) begin
      if (k % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 5;
          2: idle_pct = 25;
          default: idle_pct = 60;
        endcase
      end
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      base = pal_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
      if (roll < 30) begin
        if (pick < 60) color = COLOR_W'($urandom);
        else if (pick < 85) color = base;
        else color = {($urandom_range(0, 1) != 0) ? 8'hff : 8'h00,
                      ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00,
                      ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00};
        send_load(INDEX_W'($urandom), color);
      end else begin
        if (pick < 30) color = COLOR_W'($urandom);
        else if (pick < 55) color = last_query_color;
        else if (pick < 75) color = base;
        else if (pick < 90) begin
          for (int c = 0; c < 3; c++)
            color[c*8 +: 8] = 8'(int'(base[c*8 +: 8]) + $urandom_range(0, 6) - 3);
        end else color = {($urandom_range(0, 1) != 0) ? 8'hff : 8'h00,
                          ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00,
                          ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00};
        send_query(color);
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_nearest(out_if.nearest_index);
      if (hold_off_req != 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      out_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    in_if.valid       <= 1'b0;
    in_if.op          <= npc_pkg::OP_LOAD;
    in_if.entry_index <= '0;
    in_if.red         <= '0;
    in_if.green       <= '0;
    in_if.blue        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_palette_fill();
    test_directed_queries();
    test_tie_break();
    test_far_query();
    test_output_stall();
    test_random_traffic(740);

    in_if.valid <= 1'b0;
    while (expected_index_q.size() != 0) @(posedge clk);
    repeat (PALETTE_ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/npc_pkg.sv
hdl/npc_if.sv
hdl/npc_palette_mem.sv
hdl/npc_scan.sv
hdl/nearest_palette_color_top.sv
hdl/npc_checker.sv
tb/nearest_palette_color_top_test.sv
